// ===== rtl/psr_pkg.sv =====
package psr_pkg;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_SWEEP = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [2:0] REG_COLS  = 3'd0;
	localparam logic [2:0] REG_ROWS  = 3'd1;
	localparam logic [2:0] REG_WH    = 3'd2;
	localparam logic [2:0] REG_WV    = 3'd3;
	localparam logic [2:0] REG_WS    = 3'd4;
	localparam logic [2:0] REG_TOL   = 3'd5;
	localparam logic [2:0] REG_MAXSW = 3'd6;

	localparam int IDX_BITS = 12;
	localparam int IN_BITS  = 80;
	localparam int OUT_BITS = 64;

	localparam logic [4:0] OP_NONE    = 5'd0;
	localparam logic [4:0] OP_CAPTURE = 5'd1;
	localparam logic [4:0] OP_DIV     = 5'd2;
	localparam logic [4:0] OP_PRE     = 5'd3;
	localparam logic [4:0] OP_LDWR    = 5'd4;
	localparam logic [4:0] OP_RDPT    = 5'd5;
	localparam logic [4:0] OP_RD_OWN  = 5'd6;
	localparam logic [4:0] OP_RD_L    = 5'd7;
	localparam logic [4:0] OP_RD_R    = 5'd8;
	localparam logic [4:0] OP_RD_U    = 5'd9;
	localparam logic [4:0] OP_RD_D    = 5'd10;
	localparam logic [4:0] OP_MUL_H   = 5'd11;
	localparam logic [4:0] OP_MUL_V   = 5'd12;
	localparam logic [4:0] OP_MUL_S   = 5'd13;
	localparam logic [4:0] OP_RES     = 5'd14;
	localparam logic [4:0] OP_DECIDE  = 5'd15;
	localparam logic [4:0] OP_UPD_RD  = 5'd16;
	localparam logic [4:0] OP_UPD_MUL = 5'd17;
	localparam logic [4:0] OP_UPD_WR  = 5'd18;
	localparam logic [4:0] OP_OUT     = 5'd19;

	typedef struct packed {
		logic [6:0]  cols;
		logic [6:0]  rows;
		logic [23:0] wh;
		logic [23:0] wv;
		logic [23:0] ws;
		logic [30:0] tol;
		logic [30:0] maxsw;
	} cfg_t;

	typedef struct packed {
		logic [4:0] op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       in_grid;
		logic       stop;
		logic       out_busy;
	} stat_t;

endpackage

// ===== rtl/psr_regs.sv =====
module psr_regs import psr_pkg::*; #(
	parameter int MAX_SIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [6:0]  cols_q, rows_q;
	logic [23:0] wh_q, wv_q, ws_q;
	logic [30:0] tol_q, maxsw_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= 7'd64;
			rows_q  <= 7'd64;
			wh_q    <= 24'd4194304;
			wv_q    <= 24'd4194304;
			ws_q    <= 24'd1024;
			tol_q   <= 31'd64;
			maxsw_q <= 31'd1000000;
		end else if (wr) begin
			case (paddr[4:2])
				REG_COLS:  cols_q  <= pwdata[6:0];
				REG_ROWS:  rows_q  <= pwdata[6:0];
				REG_WH:    wh_q    <= pwdata[23:0];
				REG_WV:    wv_q    <= pwdata[23:0];
				REG_WS:    ws_q    <= pwdata[23:0];
				REG_TOL:   tol_q   <= pwdata[30:0];
				REG_MAXSW: maxsw_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_COLS:  prdata = {25'd0, cols_q};
			REG_ROWS:  prdata = {25'd0, rows_q};
			REG_WH:    prdata = {8'd0, wh_q};
			REG_WV:    prdata = {8'd0, wv_q};
			REG_WS:    prdata = {8'd0, ws_q};
			REG_TOL:   prdata = {1'b0, tol_q};
			REG_MAXSW: prdata = {1'b0, maxsw_q};
			default:   prdata = 32'd0;
		endcase
	end

	function automatic logic [6:0] clamp_side(input logic [6:0] s);
		if (s < 7'd3) return 7'd3;
		if (int'(s) > MAX_SIDE) return 7'(MAX_SIDE);
		return s;
	endfunction

	always_comb begin
		cfg.cols  = clamp_side(cols_q);
		cfg.rows  = clamp_side(rows_q);
		cfg.wh    = wh_q;
		cfg.wv    = wv_q;
		cfg.ws    = ws_q;
		cfg.tol   = tol_q;
		cfg.maxsw = maxsw_q;
	end

endmodule

// ===== rtl/psr_ctrl.sv =====
module psr_ctrl import psr_pkg::*; #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  stat_t         stat,
	input  logic          s_tvalid,
	output logic          s_tready,
	output cmd_t          cmd,
	output logic [AW-1:0] ptr
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_DIV    = 4'd2;
	localparam logic [3:0] S_PRE    = 4'd3;
	localparam logic [3:0] S_LDWR   = 4'd4;
	localparam logic [3:0] S_RDPT   = 4'd5;
	localparam logic [3:0] S_RDWAIT = 4'd6;
	localparam logic [3:0] S_P1     = 4'd7;
	localparam logic [3:0] S_DECIDE = 4'd8;
	localparam logic [3:0] S_P2     = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]    state_q;
	logic [3:0]    k_q;
	logic [6:0]    r_q, c_q;
	logic [AW-1:0] m_q;
	logic          row_end, last_pt;

	assign ptr      = m_q;
	assign s_tready = (state_q == S_IDLE);
	assign row_end  = ({1'b0, c_q} + 8'd2 == {1'b0, cfg.cols});
	assign last_pt  = row_end && ({1'b0, r_q} + 8'd2 == {1'b0, cfg.rows});

	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE:   cmd.op = s_tvalid ? OP_CAPTURE : OP_NONE;
			S_DIV:    cmd.op = OP_DIV;
			S_PRE:    cmd.op = OP_PRE;
			S_LDWR:   cmd.op = OP_LDWR;
			S_RDPT:   cmd.op = OP_RDPT;
			S_DECIDE: cmd.op = OP_DECIDE;
			S_DONE:   cmd.op = stat.out_busy ? OP_NONE : OP_OUT;
			S_P1: begin
				case (k_q)
					4'd0: cmd.op = OP_RD_OWN;
					4'd1: cmd.op = OP_RD_L;
					4'd2: cmd.op = OP_RD_R;
					4'd3: cmd.op = OP_RD_U;
					4'd4: cmd.op = OP_RD_D;
					4'd5: cmd.op = OP_MUL_H;
					4'd6: cmd.op = OP_MUL_V;
					4'd7: cmd.op = OP_MUL_S;
					default: cmd.op = OP_RES;
				endcase
			end
			S_P2: begin
				case (k_q)
					4'd0: cmd.op = OP_UPD_RD;
					4'd1: cmd.op = OP_UPD_MUL;
					default: cmd.op = OP_UPD_WR;
				endcase
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			r_q     <= '0;
			c_q     <= '0;
			m_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_DISP;
				S_DISP: begin
					k_q <= '0;
					r_q <= 7'd1;
					c_q <= 7'd1;
					m_q <= AW'(cfg.cols) + AW'(1);
					case (stat.mode)
						MODE_LOAD:  state_q <= stat.in_grid ? S_DIV : S_DONE;
						MODE_SWEEP: state_q <= S_P1;
						MODE_READ:  state_q <= stat.in_grid ? S_RDPT : S_DONE;
						default:    state_q <= S_DONE;
					endcase
				end
				S_DIV: begin
					k_q <= k_q + 4'd1;
					if (k_q == 4'(IDX_BITS - 1)) state_q <= S_PRE;
				end
				S_PRE:    state_q <= S_LDWR;
				S_LDWR:   state_q <= S_DONE;
				S_RDPT:   state_q <= S_RDWAIT;
				S_RDWAIT: state_q <= S_DONE;
				S_P1, S_P2: begin
					if ((state_q == S_P1 && k_q == 4'd8) || (state_q == S_P2 && k_q == 4'd2)) begin
						k_q <= '0;
						if (row_end) begin
							c_q <= 7'd1;
							r_q <= r_q + 7'd1;
							m_q <= m_q + AW'(3);
						end else begin
							c_q <= c_q + 7'd1;
							m_q <= m_q + AW'(1);
						end
						if (last_pt) state_q <= (state_q == S_P1) ? S_DECIDE : S_DONE;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_DECIDE: begin
					k_q <= '0;
					r_q <= 7'd1;
					c_q <= 7'd1;
					m_q <= AW'(cfg.cols) + AW'(1);
					state_q <= stat.stop ? S_DONE : S_P2;
				end
				S_DONE: if (!stat.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/psr_dp.sv =====
module psr_dp import psr_pkg::*; #(
	parameter int AW         = 12,
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	input  logic [AW-1:0]       ptr,
	input  logic [IN_BITS-1:0]  s_tdata,
	input  logic [1:0]          s_tuser,
	output stat_t               stat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_BITS-1:0] m_tdata
);

	localparam int EFF   = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
	localparam int DEPTH = 1 << AW;
	localparam logic signed [63:0] VMAX = 64'((64'sd1 <<< (EFF - 1)) - 64'sd1);

	logic [31:0] sol_mem [DEPTH];
	logic [31:0] src_mem [DEPTH];
	logic [31:0] res_mem [DEPTH];

	logic [1:0]          mode_q;
	logic [IDX_BITS-1:0] idx_q;
	logic signed [31:0]  srcin_q;
	logic [31:0]         tau_q;
	logic [4:0]          op_d1;
	logic [7:0]          rem_q;
	logic [IDX_BITS-1:0] quo_q;
	logic signed [63:0]  pre_q;
	logic signed [31:0]  sol_rd, src_rd, res_rd;
	logic signed [31:0]  own_q, srcv_q;
	logic signed [32:0]  hsum_q, vsum_q;
	logic signed [63:0]  acc_q;
	logic signed [64:0]  uprod_q;
	logic [30:0]         maxabs_q;
	logic [30:0]         count_q;
	logic                conv_q;
	logic [31:0]         result_q;
	logic [AW-1:0]       addr, cols_a, idx_a;
	logic [7:0]          div_t;
	logic [13:0]         npts;
	logic                interior;
	logic signed [31:0]  res_v, pre_v, upd_v;
	logic signed [32:0]  abs_v;

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		if (v > VMAX) return 32'(VMAX);
		if (v < -VMAX - 64'sd1) return 32'(-VMAX - 64'sd1);
		return v[31:0];
	endfunction

	assign cols_a = AW'(cfg.cols);
	assign idx_a  = AW'(idx_q);
	assign npts   = 14'(cfg.cols * cfg.rows);

	assign stat.mode     = mode_q;
	assign stat.in_grid  = {2'b0, idx_q} < npts;
	assign stat.stop     = (maxabs_q <= cfg.tol) || (count_q >= cfg.maxsw);
	assign stat.out_busy = m_tvalid && !m_tready;

	always_comb begin
		case (cmd.op)
			OP_RD_L:          addr = ptr - AW'(1);
			OP_RD_R:          addr = ptr + AW'(1);
			OP_RD_U:          addr = ptr - cols_a;
			OP_RD_D:          addr = ptr + cols_a;
			OP_LDWR, OP_RDPT: addr = idx_a;
			default:          addr = ptr;
		endcase
	end

	assign div_t = {rem_q[6:0], quo_q[IDX_BITS-1]};
	assign interior = (quo_q != '0) && ({1'b0, quo_q} + 13'd1 < {6'd0, cfg.rows})
		&& (rem_q != 8'd0) && (rem_q + 8'd1 < {1'b0, cfg.cols});

	// residual: round the weighted sum to Q8.24, subtract own
	assign res_v = sat(64'((acc_q + 64'sd8388608) >>> 24) - 64'(own_q));
	assign abs_v = res_v[31] ? -33'(res_v) : 33'(res_v);
	assign pre_v = interior ? sat((pre_q + 64'sd8388608) >>> 24) : 32'sd0;
	assign upd_v = sat(64'(own_q) + 64'((uprod_q + 65'sd32768) >>> 16));

	always_ff @(posedge clk) begin
		sol_rd <= sol_mem[addr];
		src_rd <= src_mem[addr];
		res_rd <= res_mem[addr];
		if (cmd.op == OP_LDWR) begin
			sol_mem[addr] <= pre_v;
			src_mem[addr] <= srcin_q;
		end
		if (cmd.op == OP_UPD_WR) sol_mem[addr] <= upd_v;
		if (cmd.op == OP_RES) res_mem[addr] <= res_v;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				idx_q   <= s_tdata[11:0];
				srcin_q <= s_tdata[43:12];
				tau_q   <= s_tdata[75:44];
				rem_q   <= '0;
				quo_q   <= s_tdata[11:0];
			end
			OP_DIV: begin
				if (div_t >= {1'b0, cfg.cols}) begin
					rem_q <= div_t - {1'b0, cfg.cols};
					quo_q <= {quo_q[IDX_BITS-2:0], 1'b1};
				end else begin
					rem_q <= div_t;
					quo_q <= {quo_q[IDX_BITS-2:0], 1'b0};
				end
			end
			OP_PRE:     pre_q <= 64'($signed({1'b0, cfg.ws}) * srcin_q);
			OP_MUL_H:   acc_q <= 64'($signed({1'b0, cfg.wh}) * hsum_q);
			OP_MUL_V:   acc_q <= acc_q + 64'($signed({1'b0, cfg.wv}) * vsum_q);
			OP_MUL_S:   acc_q <= acc_q + 64'($signed({1'b0, cfg.ws}) * srcv_q);
			OP_UPD_MUL: begin
				uprod_q <= 65'($signed({1'b0, tau_q}) * res_rd);
				own_q   <= sol_rd;
			end
			default: ;
		endcase
		// read data lands in the cycle after its address
		case (op_d1)
			OP_RD_OWN: begin
				own_q  <= sol_rd;
				srcv_q <= src_rd;
			end
			OP_RD_L: hsum_q <= 33'(sol_rd);
			OP_RD_R: hsum_q <= hsum_q + 33'(sol_rd);
			OP_RD_U: vsum_q <= 33'(sol_rd);
			OP_RD_D: vsum_q <= vsum_q + 33'(sol_rd);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_d1    <= OP_NONE;
			mode_q   <= MODE_LOAD;
			maxabs_q <= '0;
			count_q  <= '0;
			conv_q   <= 1'b0;
			result_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			op_d1 <= cmd.op;
			if (cmd.op == OP_OUT) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {count_q, conv_q, result_q};
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (cmd.op)
				OP_CAPTURE: begin
					mode_q   <= s_tuser;
					result_q <= '0;
					maxabs_q <= '0;
				end
				OP_LDWR: result_q <= pre_v;
				OP_RES: begin
					if (abs_v > 33'(VMAX)) begin
						if (31'(VMAX) > maxabs_q) maxabs_q <= 31'(VMAX);
					end else if (abs_v[30:0] > maxabs_q) begin
						maxabs_q <= abs_v[30:0];
					end
				end
				OP_DECIDE: begin
					result_q <= {1'b0, maxabs_q};
					conv_q   <= stat.stop;
					if (!stat.stop && count_q != '1) count_q <= count_q + 31'd1;
				end
				default: ;
			endcase
			if (op_d1 == OP_RDPT) result_q <= sol_rd;
		end
	end

endmodule

// ===== rtl/poisson_stencil_relaxation_core.sv =====
// Five-point Poisson relaxation engine, Q8.24 values with saturation. One result beat per
// input beat; items are worked one at a time. A load runs a 12-step index divider, a preset
// multiply and a store write; a read fetches one point; a sweep runs a residual pass over
// the interior points and then an update pass (skipped when the sweep converges). The
// residual pass is bound by the single read port of the solution memory (five reads per
// point, own value and four neighbors) and the shared multiplier.
// Solution, source and residual memories are uncleared; read only points that were loaded.
module poisson_stencil_relaxation_core import psr_pkg::*; #(
	parameter int MAX_SIDE   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_BITS-1:0]  s_tdata,  // point_index, source_value, step_factor, 4'b0 pad
	input  logic [1:0]          s_tuser,  // mode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_BITS-1:0] m_tdata,  // result_value, converged, sweep_count
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

	cfg_t          cfg;
	cmd_t          cmd;
	stat_t         stat;
	logic [AW-1:0] ptr;

	psr_regs #(.MAX_SIDE(MAX_SIDE)) u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	psr_ctrl #(.AW(AW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .stat(stat), .s_tvalid(s_tvalid),
		.s_tready(s_tready), .cmd(cmd), .ptr(ptr)
	);

	psr_dp #(.AW(AW), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd), .ptr(ptr), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .stat(stat), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ===== tb/sv/poisson_stencil_relaxation_core_tb.sv =====
`timescale 1ns / 100ps

module poisson_stencil_relaxation_core_tb;
	import psr_pkg::*;

	localparam int SIDE_MAX = 64;
	localparam int DEPTH = SIDE_MAX * SIDE_MAX;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam int STALL_LIMIT = 20000;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_BITS-1:0]  s_tdata;
	logic [1:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_BITS-1:0] m_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [4:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	typedef struct packed {
		logic [30:0] sweeps;
		logic        conv;
		logic [31:0] value;
	} point_result_t;

	logic [31:0] soln_mem [DEPTH];
	logic [31:0] src_mem [DEPTH];
	bit          loaded [DEPTH];
	logic [31:0] resid_mem [DEPTH];
	logic [30:0] sweeps_done;
	logic        conv_flag;
	logic [6:0]  cols_reg;
	logic [6:0]  rows_reg;
	logic [23:0] wh_reg;
	logic [23:0] wv_reg;
	logic [23:0] ws_reg;
	logic [30:0] tol_reg;
	logic [30:0] maxsw_reg;

	point_result_t pending_results[$];
	bit failed;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	poisson_stencil_relaxation_core uut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint sat32(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	// arithmetic shift is a floor shift; add half first to round to nearest, ties upward
	function automatic longint round_shr(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic int side_of(logic [6:0] s);
		if (s < 3) return 3;
		if (s > SIDE_MAX) return SIDE_MAX;
		return int'(s);
	endfunction

	function automatic point_result_t predict_point(logic [1:0] mode, logic [11:0] idx,
			logic [31:0] src, logic [31:0] tau);
		point_result_t res;
		int cols;
		int rows;
		int m;
		longint acc;
		longint rv;
		longint mag;
		longint maxabs;
		longint outv;
		cols = side_of(cols_reg);
		rows = side_of(rows_reg);
		outv = 0;
		case (mode)
			MODE_LOAD: begin
				if (idx < cols * rows) begin
					src_mem[idx] = src;
					loaded[idx] = 1'b1;
					if (idx / cols > 0 && idx / cols < rows - 1 && idx % cols > 0
							&& idx % cols < cols - 1)
						outv = sat32(round_shr(longint'(ws_reg) * longint'($signed(src)), 24));
					soln_mem[idx] = outv[31:0];
				end
			end
			MODE_SWEEP: begin
				maxabs = 0;
				for (int r = 1; r < rows - 1; r++)
					for (int c = 1; c < cols - 1; c++) begin
						m = r * cols + c;
						acc = longint'(wh_reg) * (longint'($signed(soln_mem[m - 1]))
								+ longint'($signed(soln_mem[m + 1])))
							+ longint'(wv_reg) * (longint'($signed(soln_mem[m - cols]))
								+ longint'($signed(soln_mem[m + cols])))
							+ longint'(ws_reg) * longint'($signed(src_mem[m]));
						rv = sat32(round_shr(acc, 24) - longint'($signed(soln_mem[m])));
						mag = rv < 0 ? -rv : rv;
						if (mag > VMAX) mag = VMAX;
						resid_mem[m] = rv[31:0];
						if (mag > maxabs) maxabs = mag;
					end
				outv = maxabs;
				if (maxabs <= tol_reg || sweeps_done >= maxsw_reg) begin
					conv_flag = 1'b1;
				end else begin
					conv_flag = 1'b0;
					if (sweeps_done != 31'h7FFFFFFF) sweeps_done++;
					for (int r = 1; r < rows - 1; r++)
						for (int c = 1; c < cols - 1; c++) begin
							m = r * cols + c;
							rv = longint'($signed(soln_mem[m]))
								+ round_shr(longint'(tau) * longint'($signed(resid_mem[m])), 16);
							soln_mem[m] = 32'(sat32(rv));
						end
				end
			end
			MODE_READ: begin
				if (idx < cols * rows) outv = longint'($signed(soln_mem[idx]));
			end
			default: ;
		endcase
		res.value = outv[31:0];
		res.conv = conv_flag;
		res.sweeps = sweeps_done;
		return res;
	endfunction

	task automatic send_point(logic [1:0] mode, logic [11:0] idx, logic [31:0] src,
			logic [31:0] tau);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		pending_results.push_back(predict_point(mode, idx, src, tau));
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {4'b0, tau, src, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] reg_idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (reg_idx)
			REG_COLS:  cols_reg = value[6:0];
			REG_ROWS:  rows_reg = value[6:0];
			REG_WH:    wh_reg = value[23:0];
			REG_WV:    wv_reg = value[23:0];
			REG_WS:    ws_reg = value[23:0];
			REG_TOL:   tol_reg = value[30:0];
			REG_MAXSW: maxsw_reg = value[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_grid(int cols, int rows);
		write_reg(REG_COLS, cols);
		write_reg(REG_ROWS, rows);
	endtask

	// load the whole clamped grid so sweeps never touch unloaded points
	task automatic load_grid(int mag);
		int n;
		n = side_of(cols_reg) * side_of(rows_reg);
		for (int i = 0; i < n; i++)
			send_point(MODE_LOAD, 12'(i), 32'($urandom_range(mag) - mag / 2), $urandom());
	endtask

	function automatic logic [11:0] loaded_index();
		int n;
		logic [11:0] idx;
		n = side_of(cols_reg) * side_of(rows_reg);
		idx = 12'($urandom_range(n - 1));
		if ($urandom_range(9) == 0) idx = 12'($urandom());
		if (idx >= n) return idx;
		return loaded[idx] ? idx : 12'd0;
	endfunction

	task automatic test_directed();
		set_grid(3, 3);
		write_reg(REG_WS, 32'hFFFFFF);
		write_reg(REG_WH, 32'h400000);
		write_reg(REG_WV, 32'h400000);
		write_reg(REG_TOL, 0);
		write_reg(REG_MAXSW, 32'h7FFFFFFF);
		send_point(MODE_LOAD, 4, 32'h7FFFFFFF, 0);
		send_point(MODE_LOAD, 4, 32'h80000000, 0);
		for (int i = 0; i < 9; i++) send_point(MODE_LOAD, 12'(i), 32'h01000000 * i, 0);
		send_point(MODE_LOAD, 12'hFFF, 32'h12345678, 0);
		send_point(MODE_READ, 12'hFFF, 0, 0);
		send_point(2'd3, 4, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_point(MODE_SWEEP, 0, 0, 32'h00008000);
		send_point(MODE_SWEEP, 0, 0, 32'hFFFFFFFF);
		send_point(MODE_READ, 4, 0, 0);
		send_point(MODE_SWEEP, 0, 0, 0);
		drain_results();
		write_reg(REG_MAXSW, 0);
		send_point(MODE_SWEEP, 0, 0, 32'h00010000);
		drain_results();
		write_reg(REG_TOL, 32'h7FFFFFFF);
		write_reg(REG_MAXSW, 1000000);
		send_point(MODE_SWEEP, 0, 0, 32'h00010000);
		send_point(MODE_READ, 0, 0, 0);
		drain_results();
		// sides below and above range clamp to a 3-wide, 64-high grid
		set_grid(0, 127);
		send_point(MODE_LOAD, 12'd4, 32'h00123456, 0);
		send_point(MODE_LOAD, 12'd191, 32'h00654321, 0);
		send_point(MODE_LOAD, 12'd192, 32'h00111111, 0);
		send_point(MODE_READ, 12'd4, 0, 0);
		send_point(MODE_READ, 12'd191, 0, 0);
		send_point(MODE_READ, 12'd192, 0, 0);
		drain_results();
	endtask

	task automatic test_random(int items);
		int kind;
		int done;
		done = 0;
		while (done < items) begin
			drain_results();
			set_grid($urandom_range(3, 5), $urandom_range(3, 5));
			write_reg(REG_WH, $urandom_range(24'h500000, 24'h300000));
			write_reg(REG_WV, $urandom_range(24'h500000, 24'h300000));
			write_reg(REG_WS, $urandom());
			write_reg(REG_TOL, $urandom_range(1 << 20));
			write_reg(REG_MAXSW, $urandom_range(30));
			load_grid(32'h04000000);
			for (int k = 0; k < 20 && done < items; k++) begin
				kind = $urandom_range(9);
				if (kind < 4)
					send_point(MODE_SWEEP, 12'($urandom()), $urandom(),
						$urandom_range(32'h10000));
				else if (kind < 8)
					send_point(MODE_READ, loaded_index(), $urandom(), $urandom());
				else if (kind < 9)
					send_point(MODE_LOAD, 12'($urandom()), $urandom(), $urandom());
				else
					send_point(2'd3, 12'($urandom()), $urandom(), $urandom());
				done++;
			end
		end
		drain_results();
	endtask

	task automatic test_large_grid();
		set_grid(64, 64);
		write_reg(REG_WS, 1024);
		write_reg(REG_WH, 4194304);
		write_reg(REG_WV, 4194304);
		write_reg(REG_TOL, 64);
		write_reg(REG_MAXSW, 5);
		send_point(MODE_LOAD, 12'd65, 32'h7FFFFFFF, 0);
		send_point(MODE_LOAD, 12'd4030, 32'h80000000, 0);
		send_point(MODE_LOAD, 12'd4095, 32'h01234567, 0);
		send_point(MODE_LOAD, 12'd127, 32'h01234567, 0);
		send_point(MODE_READ, 12'd65, 0, 0);
		send_point(MODE_READ, 12'd4030, 0, 0);
		send_point(MODE_READ, 12'd4095, 0, 0);
		send_point(MODE_READ, 12'd127, 0, 0);
		drain_results();
	endtask

	always @(posedge clk) begin
		point_result_t want;
		point_result_t got;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value) begin
					$error("result_value expected %h actual %h", want.value, got.value);
					failed = 1'b1;
				end
				if (got.conv !== want.conv) begin
					$error("converged expected %b actual %b", want.conv, got.conv);
					failed = 1'b1;
				end
				if (got.sweeps !== want.sweeps) begin
					$error("sweep_count expected %0d actual %0d", want.sweeps, got.sweeps);
					failed = 1'b1;
				end
			end
		end
		m_tready <= $urandom_range(99) >= recv_idle_pct;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		failed = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sweeps_done = '0;
		conv_flag = 1'b0;
		cols_reg = 64;
		rows_reg = 64;
		wh_reg = 4194304;
		wv_reg = 4194304;
		ws_reg = 1024;
		tol_reg = 64;
		maxsw_reg = 1000000;
		for (int i = 0; i < DEPTH; i++) loaded[i] = 1'b0;
		send_idle_pct = 22;
		recv_idle_pct = 52;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(10);
		send_idle_pct = 52;
		recv_idle_pct = 22;
		test_random(10);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(8);
		test_large_grid();
		drain_results();
		if (!failed) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
